@@ design/ssdbd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssdbd_pkg
// shared types, constants and table helpers for the ssd box decoder
// ----------------------------------------------------------------------------
package ssdbd_pkg;

    // default sizes
    localparam int VALUE_WIDTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 12;
    localparam int TABLE_DEPTH_DEF   = 256;

    // configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RECIP_SCALE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_RECIP_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_H_RECIP_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_W_RECIP_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT     = 3'd5;

    localparam logic [15:0] RST_SCORE_THRESHOLD = 16'd39322;
    localparam logic [15:0] RST_CENTRE_RECIP    = 16'd6554;
    localparam logic [15:0] RST_SIZE_RECIP      = 16'd13107;
    localparam logic [7:0]  RST_CLASS_COUNT     = 8'd91;

    // field widths
    localparam int SCORE_W = 16;
    localparam int LABEL_W = 9;
    localparam int DET_W   = 16;
    localparam int CLASS_W = 8;
    localparam int RECIP_W = 16;

    // arithmetic constants
    localparam int    SCALE_SHIFT = 16;
    localparam int    MUL_B_W     = 33;
    localparam int    TAB_W       = 32;
    localparam int    HALF_W      = 42;
    localparam int    MAG_W       = 41;
    localparam int    EXP_N_W     = 8;
    localparam int    EXP_CLAMP   = 64;
    localparam int    DEN_W       = 63;
    localparam int    REM_W       = 47;
    localparam int    QUO_W       = 17;
    localparam int    DIV_STEPS   = 17;
    localparam int    CNT_W       = 5;
    localparam int    LOG2E_Q16   = 94548;
    localparam longint LN2_Q30    = 744261118;

    typedef enum logic [4:0] {
        ST_IDLE, ST_TY, ST_TX, ST_YC, ST_XC,
        ST_UH, ST_VH, ST_SH, ST_MH, ST_HH,
        ST_UW, ST_VW, ST_SW, ST_MW, ST_HW,
        ST_CORN, ST_LV, ST_LS, ST_LE, ST_DIV, ST_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_TY, OP_TX, OP_YC, OP_XC,
        OP_UH, OP_VH, OP_SH, OP_MH, OP_HH,
        OP_UW, OP_VW, OP_SW, OP_MW, OP_HW,
        OP_CORN, OP_LV, OP_LS, OP_LE, OP_DIV, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic mode;
        logic cls_done;
        logic pass;
        logic out_free;
    } t_sts;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // 2^(k/depth) in q.30, truncated taylor series of exp(k*ln2/depth)
    function automatic logic [TAB_W-1:0] pow2_entry(input int k, input int tb);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (64'(k) * 64'(LN2_Q30)) >> tb;
        term = 64'd1 << 30;
        sum  = term;
        for (int i = 1; i <= 15; i++) begin
            term = ((term * x) >> 30) / 64'(i);
            sum  = sum + term;
        end
        return sum[TAB_W-1:0];
    endfunction

endpackage

@@ design/ssdbd_in_if.sv @@
// ----------------------------------------------------------------------------
// ssdbd_in_if
// input channel: box items and class logit items
// ----------------------------------------------------------------------------
interface ssdbd_in_if
    import ssdbd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic signed [VALUE_WIDTH-1:0] enc_y;
    logic signed [VALUE_WIDTH-1:0] enc_x;
    logic signed [VALUE_WIDTH-1:0] enc_h;
    logic signed [VALUE_WIDTH-1:0] enc_w;
    logic signed [VALUE_WIDTH-1:0] anchor_y;
    logic signed [VALUE_WIDTH-1:0] anchor_x;
    logic signed [VALUE_WIDTH-1:0] anchor_h;
    logic signed [VALUE_WIDTH-1:0] anchor_w;
    logic signed [VALUE_WIDTH-1:0] logit;
    logic                          new_frame;

    modport source (
        output valid, mode, enc_y, enc_x, enc_h, enc_w,
               anchor_y, anchor_x, anchor_h, anchor_w, logit, new_frame,
        input  ready
    );

    modport sink (
        input  valid, mode, enc_y, enc_x, enc_h, enc_w,
               anchor_y, anchor_x, anchor_h, anchor_w, logit, new_frame,
        output ready
    );
endinterface

@@ design/ssdbd_out_if.sv @@
// ----------------------------------------------------------------------------
// ssdbd_out_if
// output channel: one detection per passing logit item
// ----------------------------------------------------------------------------
interface ssdbd_out_if
    import ssdbd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] box_ymin;
    logic signed [VALUE_WIDTH-1:0] box_xmin;
    logic signed [VALUE_WIDTH-1:0] box_ymax;
    logic signed [VALUE_WIDTH-1:0] box_xmax;
    logic        [SCORE_W-1:0]     score;
    logic signed [LABEL_W-1:0]     class_label;
    logic        [DET_W-1:0]       detection_index;

    modport source (
        output valid, box_ymin, box_xmin, box_ymax, box_xmax,
               score, class_label, detection_index,
        input  ready
    );

    modport sink (
        input  valid, box_ymin, box_xmin, box_ymax, box_xmax,
               score, class_label, detection_index,
        output ready
    );
endinterface

@@ design/ssdbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssdbd_ctrl
// sequencer: steps the shared datapath through box and logit work
// ----------------------------------------------------------------------------
module ssdbd_ctrl
    import ssdbd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_sts.in_valid) begin
                    if (!i_sts.mode) begin
                        n_state = ST_TY;
                    end else if (!i_sts.cls_done) begin
                        n_state = ST_LV;
                    end
                end
            end
            ST_TY:   n_state = ST_TX;
            ST_TX:   n_state = ST_YC;
            ST_YC:   n_state = ST_XC;
            ST_XC:   n_state = ST_UH;
            ST_UH:   n_state = ST_VH;
            ST_VH:   n_state = ST_SH;
            ST_SH:   n_state = ST_MH;
            ST_MH:   n_state = ST_HH;
            ST_HH:   n_state = ST_UW;
            ST_UW:   n_state = ST_VW;
            ST_VW:   n_state = ST_SW;
            ST_SW:   n_state = ST_MW;
            ST_MW:   n_state = ST_HW;
            ST_HW:   n_state = ST_CORN;
            ST_CORN: n_state = ST_IDLE;
            ST_LV:   n_state = ST_LS;
            ST_LS:   n_state = ST_LE;
            ST_LE:   n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!i_sts.pass || i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.op   = i_sts.in_valid ? OP_LOAD : OP_NONE;
            end
            ST_TY:   o_cmd.op = OP_TY;
            ST_TX:   o_cmd.op = OP_TX;
            ST_YC:   o_cmd.op = OP_YC;
            ST_XC:   o_cmd.op = OP_XC;
            ST_UH:   o_cmd.op = OP_UH;
            ST_VH:   o_cmd.op = OP_VH;
            ST_SH:   o_cmd.op = OP_SH;
            ST_MH:   o_cmd.op = OP_MH;
            ST_HH:   o_cmd.op = OP_HH;
            ST_UW:   o_cmd.op = OP_UW;
            ST_VW:   o_cmd.op = OP_VW;
            ST_SW:   o_cmd.op = OP_SW;
            ST_MW:   o_cmd.op = OP_MW;
            ST_HW:   o_cmd.op = OP_HW;
            ST_CORN: o_cmd.op = OP_CORN;
            ST_LV:   o_cmd.op = OP_LV;
            ST_LS:   o_cmd.op = OP_LS;
            ST_LE:   o_cmd.op = OP_LE;
            ST_DIV:  o_cmd.op = OP_DIV;
            ST_EMIT: o_cmd.op = OP_EMIT;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == CNT_W'(DIV_STEPS - 1)) |=> (r_state == ST_EMIT))
        else $error("divider did not hand over to emit");

    a_box_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CORN) |=> (r_state == ST_IDLE))
        else $error("box sequence did not return to idle");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_DIV) |-> (r_cnt == '0))
        else $error("step count left over outside the divider");

endmodule

@@ design/ssdbd_dp.sv @@
// ----------------------------------------------------------------------------
// ssdbd_dp
// datapath: shared multiplier, exp table, divider, corner store, output register
// ----------------------------------------------------------------------------
module ssdbd_dp
    import ssdbd_pkg::*;
#(
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ssdbd_in_if.sink              i_item,
    ssdbd_out_if.source           o_det,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts
);

    localparam int VW  = VALUE_WIDTH;
    localparam int AW  = VW + 1;
    localparam int PW  = AW + MUL_B_W;
    localparam int TB  = $clog2(TABLE_DEPTH);
    localparam int SPL = FRACTION_BITS + SCALE_SHIFT;
    localparam int MW  = TAB_W + VW - 1;
    localparam int YW  = max_int(2 * VW - FRACTION_BITS, VW) + 1;
    localparam int CW  = max_int(YW, HALF_W) + 1;

    localparam logic signed [PW-1:0] CLAMP_HI = PW'(EXP_CLAMP);
    localparam logic signed [PW-1:0] CLAMP_LO = -CLAMP_HI;
    localparam logic signed [CW-1:0] SAT_HI   = (CW'(1) << (VW - 1)) - CW'(1);
    localparam logic signed [CW-1:0] SAT_LO   = -SAT_HI - CW'(1);
    localparam logic [MW-1:0]        HALF_CAP = MW'(1) << (MAG_W - 1);

    // exp table, constant
    logic [TAB_W-1:0] w_tab [TABLE_DEPTH];
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_tab
        localparam logic [TAB_W-1:0] P_ENTRY = pow2_entry(k, TB);
        assign w_tab[k] = P_ENTRY;
    end

    // latched item
    logic signed [VW-1:0] r_ey, r_ex, r_eh, r_ew, r_ay, r_ax, r_ah, r_aw, r_logit;
    logic                 r_nf;
    // configuration
    logic [SCORE_W-1:0] r_thr;
    logic [RECIP_W-1:0] r_rcy, r_rcx, r_rch, r_rcw;
    logic [CLASS_W-1:0] r_ccnt;
    // work registers
    logic signed [PW-1:0]      r_prod;
    logic signed [VW-1:0]      r_ty, r_tx;
    logic signed [YW-1:0]      r_yc, r_xc;
    logic signed [EXP_N_W-1:0] r_n;
    logic [TB-1:0]             r_idx;
    logic signed [HALF_W-1:0]  r_hh, r_hw;
    logic signed [VW-1:0]      r_corner [4];
    logic [CLASS_W-1:0]        r_pos;
    logic [DET_W-1:0]          r_det;
    logic signed [LABEL_W-1:0] r_label;
    logic [REM_W-1:0]          r_rem;
    logic [DEN_W-1:0]          r_dsh;
    logic [QUO_W-1:0]          r_quo;
    logic                      r_dzero;
    // output register
    logic                      r_ovalid;
    logic signed [VW-1:0]      r_o_ymin, r_o_xmin, r_o_ymax, r_o_xmax;
    logic [SCORE_W-1:0]        r_o_score;
    logic signed [LABEL_W-1:0] r_o_label;
    logic [DET_W-1:0]          r_o_det;

    logic signed [AW-1:0]      w_a;
    logic signed [MUL_B_W-1:0] w_b;
    logic signed [PW-1:0]      w_mul;
    logic signed [PW-1:0]      w_s16, w_sf, w_ip;
    logic signed [AW-1:0]      w_u;
    logic signed [AW-1:0]      w_ah_x, w_aw_x, w_abs_h, w_abs_w;
    logic signed [EXP_N_W-1:0] w_n_new;
    logic [TAB_W-1:0]          w_t;
    logic [MW-1:0]             w_m, w_r;
    logic signed [EXP_N_W:0]   w_sh;
    logic [MAG_W-1:0]          w_mag;
    logic                      w_neg;
    logic signed [HALF_W-1:0]  w_half;
    logic [DEN_W-1:0]          w_e, w_den;
    logic [SCORE_W-1:0]        w_score;
    logic                      w_pass, w_cls_done, w_out_free;
    logic signed [CW-1:0]      w_ycx, w_xcx, w_hhx, w_hwx;

    function automatic logic signed [VW-1:0] sat_v(input logic signed [CW-1:0] v);
        if (v > SAT_HI) begin
            return VW'(SAT_HI);
        end else if (v < SAT_LO) begin
            return VW'(SAT_LO);
        end
        return VW'(v);
    endfunction

    assign w_ah_x  = AW'(r_ah);
    assign w_aw_x  = AW'(r_aw);
    assign w_abs_h = r_ah[VW-1] ? -w_ah_x : w_ah_x;
    assign w_abs_w = r_aw[VW-1] ? -w_aw_x : w_aw_x;
    assign w_s16   = r_prod >>> SCALE_SHIFT;
    assign w_sf    = r_prod >>> FRACTION_BITS;
    assign w_u     = AW'(w_s16);
    assign w_t     = w_tab[r_idx];

    // shared multiplier operand select
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (i_cmd.op)
            OP_TY: begin w_a = AW'(r_ey); w_b = MUL_B_W'(r_rcy); end
            OP_TX: begin w_a = AW'(r_ex); w_b = MUL_B_W'(r_rcx); end
            OP_YC: begin w_a = AW'(r_ty); w_b = MUL_B_W'(r_ah); end
            OP_XC: begin w_a = AW'(r_tx); w_b = MUL_B_W'(r_aw); end
            OP_UH: begin w_a = AW'(r_eh); w_b = MUL_B_W'(r_rch); end
            OP_UW: begin w_a = AW'(r_ew); w_b = MUL_B_W'(r_rcw); end
            OP_VH, OP_VW: begin w_a = w_u; w_b = MUL_B_W'(LOG2E_Q16); end
            OP_MH: begin w_a = w_abs_h; w_b = MUL_B_W'(w_t); end
            OP_MW: begin w_a = w_abs_w; w_b = MUL_B_W'(w_t); end
            OP_LV: begin w_a = -AW'(r_logit); w_b = MUL_B_W'(LOG2E_Q16); end
            default: begin w_a = '0; w_b = '0; end
        endcase
    end

    assign w_mul = w_a * w_b;

    // power-of-two split: integer part clamped, table index from the fraction
    assign w_ip = r_prod >>> SPL;
    always_comb begin
        if (w_ip > CLAMP_HI) begin
            w_n_new = EXP_N_W'(EXP_CLAMP);
        end else if (w_ip < CLAMP_LO) begin
            w_n_new = -EXP_N_W'(EXP_CLAMP);
        end else begin
            w_n_new = EXP_N_W'(w_ip);
        end
    end

    // half size from table product and power of two
    assign w_m   = r_prod[MW-1:0];
    assign w_sh  = (EXP_N_W + 1)'(31) - (EXP_N_W + 1)'(r_n);
    assign w_r   = w_m >> w_sh[5:0];
    assign w_neg = (i_cmd.op == OP_HW) ? r_aw[VW-1] : r_ah[VW-1];
    always_comb begin
        if (w_m == '0 || w_sh >= (EXP_N_W + 1)'(64)) begin
            w_mag = '0;
        end else if (w_sh <= (EXP_N_W + 1)'(0)) begin
            w_mag = MAG_W'(HALF_CAP);
        end else if (w_r > HALF_CAP) begin
            w_mag = MAG_W'(HALF_CAP);
        end else begin
            w_mag = MAG_W'(w_r);
        end
        w_half = w_neg ? -HALF_W'(w_mag) : HALF_W'(w_mag);
    end

    // sigmoid denominator 1 + exp(-logit) in q.30
    always_comb begin
        if (r_n < 0) begin
            w_e = DEN_W'(w_t) >> EXP_N_W'(-r_n);
        end else if (r_n >= EXP_N_W'(32)) begin
            w_e = DEN_W'(1) << 62;
        end else begin
            w_e = DEN_W'(w_t) << r_n[4:0];
        end
        w_den = (DEN_W'(1) << 30) + w_e;
    end

    always_comb begin
        if (r_dzero) begin
            w_score = '0;
        end else if (r_quo[QUO_W-1]) begin
            w_score = '1;
        end else begin
            w_score = r_quo[SCORE_W-1:0];
        end
    end

    assign w_pass     = w_score > r_thr;
    assign w_cls_done = r_pos >= r_ccnt;
    assign w_out_free = !r_ovalid || o_det.ready;

    assign w_ycx = CW'(r_yc);
    assign w_xcx = CW'(r_xc);
    assign w_hhx = CW'(r_hh);
    assign w_hwx = CW'(r_hw);

    assign o_sts.in_valid = i_item.valid;
    assign o_sts.mode     = i_item.mode;
    assign o_sts.cls_done = w_cls_done;
    assign o_sts.pass     = w_pass;
    assign o_sts.out_free = w_out_free;

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= RST_SCORE_THRESHOLD;
            r_rcy    <= RST_CENTRE_RECIP;
            r_rcx    <= RST_CENTRE_RECIP;
            r_rch    <= RST_SIZE_RECIP;
            r_rcw    <= RST_SIZE_RECIP;
            r_ccnt   <= RST_CLASS_COUNT;
            r_pos    <= '0;
            r_det    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_corner[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SCORE_THRESHOLD: r_thr  <= i_cfg_data;
                    CFG_Y_RECIP_SCALE:   r_rcy  <= i_cfg_data;
                    CFG_X_RECIP_SCALE:   r_rcx  <= i_cfg_data;
                    CFG_H_RECIP_SCALE:   r_rch  <= i_cfg_data;
                    CFG_W_RECIP_SCALE:   r_rcw  <= i_cfg_data;
                    CFG_CLASS_COUNT:     r_ccnt <= i_cfg_data[CLASS_W-1:0];
                    default: ;
                endcase
            end
            // output valid: set by a passing emit, cleared when taken
            if (i_cmd.op == OP_EMIT && w_pass && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_det.ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    if (i_item.mode && !w_cls_done) begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                OP_CORN: begin
                    r_corner[0] <= sat_v(w_ycx - w_hhx);
                    r_corner[1] <= sat_v(w_xcx - w_hwx);
                    r_corner[2] <= sat_v(w_ycx + w_hhx);
                    r_corner[3] <= sat_v(w_xcx + w_hwx);
                    r_pos       <= '0;
                    if (r_nf) begin
                        r_det <= '0;
                    end
                end
                OP_EMIT: begin
                    if (w_pass && w_out_free) begin
                        if (r_det != '1) begin
                            r_det <= r_det + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload and work registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul;
        case (i_cmd.op)
            OP_LOAD: begin
                r_ey    <= i_item.enc_y;
                r_ex    <= i_item.enc_x;
                r_eh    <= i_item.enc_h;
                r_ew    <= i_item.enc_w;
                r_ay    <= i_item.anchor_y;
                r_ax    <= i_item.anchor_x;
                r_ah    <= i_item.anchor_h;
                r_aw    <= i_item.anchor_w;
                r_logit <= i_item.logit;
                r_nf    <= i_item.new_frame;
                r_label <= LABEL_W'(r_pos) - LABEL_W'(1);
            end
            OP_TX: r_ty <= VW'(w_s16);
            OP_YC: r_tx <= VW'(w_s16);
            OP_XC: r_yc <= YW'(w_sf) + YW'(r_ay);
            OP_UH: r_xc <= YW'(w_sf) + YW'(r_ax);
            OP_SH, OP_SW, OP_LS: begin
                r_n   <= w_n_new;
                r_idx <= r_prod[SPL-1 -: TB];
            end
            OP_HH: r_hh <= w_half;
            OP_HW: r_hw <= w_half;
            OP_LE: begin
                r_dzero <= (w_den[DEN_W-1:REM_W] != '0);
                r_dsh   <= {w_den[REM_W-1:0], {(DEN_W - REM_W){1'b0}}};
                r_rem   <= REM_W'(1) << (REM_W - 1);
                r_quo   <= '0;
            end
            OP_DIV: begin
                // restoring division, one quotient bit a step
                if (DEN_W'(r_rem) >= r_dsh) begin
                    r_rem <= r_rem - r_dsh[REM_W-1:0];
                    r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                end
                r_dsh <= r_dsh >> 1;
            end
            OP_EMIT: begin
                if (w_pass && w_out_free) begin
                    r_o_ymin  <= r_corner[0];
                    r_o_xmin  <= r_corner[1];
                    r_o_ymax  <= r_corner[2];
                    r_o_xmax  <= r_corner[3];
                    r_o_score <= w_score;
                    r_o_label <= r_label;
                    r_o_det   <= r_det;
                end
            end
            default: ;
        endcase
    end

    assign o_det.valid           = r_ovalid;
    assign o_det.box_ymin        = r_o_ymin;
    assign o_det.box_xmin        = r_o_xmin;
    assign o_det.box_ymax        = r_o_ymax;
    assign o_det.box_xmax        = r_o_xmax;
    assign o_det.score           = r_o_score;
    assign o_det.class_label     = r_o_label;
    assign o_det.detection_index = r_o_det;

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_EMIT && w_pass && w_out_free)
        |=> (o_det.valid && o_det.detection_index == $past(r_det)))
        else $error("detection not presented with its running index");

    a_box_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_CORN) |=> (r_pos == '0))
        else $error("class position not cleared by box");

    a_held_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_det.valid && !o_det.ready) |=> (o_det.valid && $stable(r_o_det)))
        else $error("waiting detection changed");

endmodule

@@ design/ssd_box_decode_score_filter_core.sv @@
// ----------------------------------------------------------------------------
// ssd_box_decode_score_filter_core
// ssd anchor box decoder with sigmoid class score filter
// ----------------------------------------------------------------------------
// usage
//   i_item : valid/ready channel. mode 0 carries an anchor's four encodings
//            and four anchor values; mode 1 carries one class logit
//   o_det  : valid/ready channel, one detection (corners, score, label,
//            running index) for each counted logit whose score beats the threshold
//   i_cfg_* : register write port, use only while the block is idle
// sequencing
//   one item in flight at a time; a single shared multiplier is stepped
//   through the work by the sequencer
//   box item   : centre, size and corner steps before the next item is taken
//   logit item : the 17-step restoring divider of the sigmoid dominates; a
//                detection shows on o_det the cycle after its emit step
//   logit past the class count : taken and dropped, no result
// reset
//   synchronous, active low; registers go to their defaults, stored
//   corners, class position and detection count clear
// back-pressure
//   a finished detection waits in the output register while the next item
//   is worked on; only a second detection waits for o_det to drain
// ----------------------------------------------------------------------------
module ssd_box_decode_score_filter_core
    import ssdbd_pkg::*;
#(
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ssdbd_in_if.sink              i_item,
    ssdbd_out_if.source           o_det,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    // ready only between items
    assign i_item.ready = w_in_ready;

    ssdbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    // multiplier, exp table, divider and result register
    ssdbd_dp #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .TABLE_DEPTH   (TABLE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .o_det      (o_det),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts)
    );

endmodule

@@ dv/tb_ssd_box_decode_score_filter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ssd_box_decode_score_filter_core
// self-checking bench for the ssd box decoder and class score filter
// ----------------------------------------------------------------------------
// an internal fixed-point predictor works out each detection when an item is
// taken; a monitor compares every detection leaving o_det with the oldest
// predicted one. directed items, register sweeps and random anchor/logit
// sequences run under several sender-idle and receiver-stall mixes
// ----------------------------------------------------------------------------
module tb_ssd_box_decode_score_filter_core
    import ssdbd_pkg::*;
();

    localparam int VW       = 16;
    localparam int FB       = 12;
    localparam int TD       = 256;
    localparam int DRAIN_CY = 40;   // a logit with no detection still runs the whole divider

    typedef struct {
        logic                 mode;
        logic signed [VW-1:0] enc_y, enc_x, enc_h, enc_w;
        logic signed [VW-1:0] anc_y, anc_x, anc_h, anc_w;
        logic signed [VW-1:0] logit;
        logic                 new_frame;
    } t_item;

    typedef struct {
        logic signed [VW-1:0]      ymin, xmin, ymax, xmax;
        logic [SCORE_W-1:0]        score;
        logic signed [LABEL_W-1:0] label;
        logic [DET_W-1:0]          det_idx;
    } t_det;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ssdbd_in_if  #(.VALUE_WIDTH(VW)) item_ch ();
    ssdbd_out_if #(.VALUE_WIDTH(VW)) det_ch ();

    ssd_box_decode_score_filter_core #(
        .VALUE_WIDTH(VW), .FRACTION_BITS(FB), .TABLE_DEPTH(TD)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_det      (det_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // predictor copy of registers and state
    logic [15:0]        thr, y_recip, x_recip, h_recip, w_recip;
    logic [7:0]         n_classes;
    logic signed [VW-1:0] corners [4];
    logic [7:0]         class_pos;
    logic [15:0]        det_count;
    longint unsigned    exp2_frac [TD];

    t_det pending_dets [$];
    int   fail_count;
    int   sender_idle_pct;
    int   receiver_stall_pct;

    // 2^(k/TD) in q.30 from a 16-term taylor series of exp
    task automatic build_exp2_table();
        longint unsigned x, term, sum;
        for (int k = 0; k < TD; k++) begin
            x = (longint'(k) * 744261118) / TD;
            term = 64'd1 << 30;
            sum = term;
            for (int i = 1; i <= 15; i++) begin
                term = ((term * x) >> 30) / i;
                sum += term;
            end
            exp2_frac[k] = {32'd0, sum[31:0]};
        end
    endtask

    function automatic longint clamp_value(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // natural exponent q (q.FB) -> power of two n and table mantissa
    function automatic void split_exp(input longint q, output longint n,
                                      output longint unsigned m);
        longint v, ip, frac;
        v = q * 94548;
        ip = v >>> (FB + 16);
        frac = v - (ip <<< (FB + 16));
        n = (ip > 64) ? 64 : ((ip < -64) ? -64 : ip);
        m = exp2_frac[(frac * TD) >>> (FB + 16)];
    endfunction

    function automatic longint half_extent(longint enc, longint recip, longint anc);
        longint u, n, sh, mag;
        longint unsigned t, prod;
        u = (enc * recip) >>> 16;
        split_exp(u, n, t);
        prod = t * ((anc < 0) ? -anc : anc);
        sh = 31 - n;
        if (prod == 0 || sh >= 64) mag = 0;
        else if (sh <= 0) mag = 64'd1 << 40;
        else begin
            prod = prod >> sh;
            mag = (prod > (64'd1 << 40)) ? (64'd1 << 40) : longint'(prod);
        end
        return (anc < 0) ? -mag : mag;
    endfunction

    function automatic logic [15:0] logit_to_score(longint lg);
        longint n;
        longint unsigned t, e, q;
        split_exp(-lg, n, t);
        if (n < 0) e = (-n >= 63) ? 0 : (t >> (-n));
        else if (n >= 32) e = 64'd1 << 62;
        else e = t << n;
        q = (64'd1 << 46) / ((64'd1 << 30) + e);
        return (q > 65535) ? 16'hffff : q[15:0];
    endfunction

    // update state for one taken item, queue a detection if one is due
    task automatic predict_item(input t_item it);
        longint yc, xc, hh, hw;
        t_det d;
        logic [15:0] sc;
        if (it.mode == 1'b0) begin
            yc = ((((longint'(it.enc_y) * longint'(y_recip)) >>> 16) * it.anc_h) >>> FB)
                 + it.anc_y;
            xc = ((((longint'(it.enc_x) * longint'(x_recip)) >>> 16) * it.anc_w) >>> FB)
                 + it.anc_x;
            hh = half_extent(it.enc_h, h_recip, it.anc_h);
            hw = half_extent(it.enc_w, w_recip, it.anc_w);
            corners[0] = VW'(clamp_value(yc - hh));
            corners[1] = VW'(clamp_value(xc - hw));
            corners[2] = VW'(clamp_value(yc + hh));
            corners[3] = VW'(clamp_value(xc + hw));
            class_pos = 0;
            if (it.new_frame) det_count = 0;
        end else if (class_pos < n_classes) begin
            d.label = $signed({1'b0, class_pos}) - 9'sd1;
            class_pos = class_pos + 8'd1;
            sc = logit_to_score(it.logit);
            if (sc > thr) begin
                d.ymin = corners[0];
                d.xmin = corners[1];
                d.ymax = corners[2];
                d.xmax = corners[3];
                d.score = sc;
                d.det_idx = det_count;
                if (det_count != 16'hffff) det_count++;
                pending_dets.push_back(d);
            end
        end
    endtask

    // receiver: random back-pressure
    always @(posedge i_clk) begin
        det_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // detection monitor
    always @(posedge i_clk) begin
        t_det d;
        if (i_rst_n && det_ch.valid && det_ch.ready) begin
            if (pending_dets.size() == 0) begin
                $display("%0t: unexpected detection expected none actual score %0d label %0d",
                         $time, det_ch.score, det_ch.class_label);
                fail_count++;
            end else begin
                d = pending_dets.pop_front();
                check_field("box_ymin", d.ymin, det_ch.box_ymin);
                check_field("box_xmin", d.xmin, det_ch.box_xmin);
                check_field("box_ymax", d.ymax, det_ch.box_ymax);
                check_field("box_xmax", d.xmax, det_ch.box_xmax);
                check_field("score", d.score, det_ch.score);
                check_field("class_label", d.label, det_ch.class_label);
                check_field("detection_index", d.det_idx, det_ch.detection_index);
            end
        end
    end

    // drive one item, hold it until taken; gaps come before the item
    task automatic send_item(input t_item it);
        if ($urandom_range(99) < sender_idle_pct) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.mode      <= it.mode;
        item_ch.enc_y     <= it.enc_y;
        item_ch.enc_x     <= it.enc_x;
        item_ch.enc_h     <= it.enc_h;
        item_ch.enc_w     <= it.enc_w;
        item_ch.anchor_y  <= it.anc_y;
        item_ch.anchor_x  <= it.anc_x;
        item_ch.anchor_h  <= it.anc_h;
        item_ch.anchor_w  <= it.anc_w;
        item_ch.logit     <= it.logit;
        item_ch.new_frame <= it.new_frame;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        predict_item(it);
    endtask

    // wait for the block to go idle, then write all registers
    task automatic program_regs(input logic [15:0] t, yr, xr, hr, wr, input logic [7:0] nc);
        logic [CFG_DATA_W-1:0] vals [6];
        logic [CFG_IDX_W-1:0]  idxs [6];
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_dets.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CY) @(posedge i_clk);
        idxs = '{CFG_SCORE_THRESHOLD, CFG_Y_RECIP_SCALE, CFG_X_RECIP_SCALE,
                 CFG_H_RECIP_SCALE, CFG_W_RECIP_SCALE, CFG_CLASS_COUNT};
        vals = '{t, yr, xr, hr, wr, {8'd0, nc}};
        for (int i = 0; i < 6; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        thr = t; y_recip = yr; x_recip = xr; h_recip = hr; w_recip = wr; n_classes = nc;
    endtask

    function automatic logic signed [VW-1:0] rand_value();
        // half full range, half moderate magnitudes so corners do not always clip
        if ($urandom_range(1)) return 16'($urandom());
        return $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
    endfunction

    function automatic t_item box_item(logic nf);
        t_item it;
        it.mode = 1'b0;
        it.enc_y = rand_value(); it.enc_x = rand_value();
        it.enc_h = rand_value(); it.enc_w = rand_value();
        it.anc_y = rand_value(); it.anc_x = rand_value();
        it.anc_h = rand_value(); it.anc_w = rand_value();
        it.logit = 16'($urandom());
        it.new_frame = nf;
        return it;
    endfunction

    function automatic t_item logit_item(logic signed [VW-1:0] lg);
        t_item it;
        it = box_item(1'($urandom_range(1)));   // box fields are don't-care on a logit
        it.mode = 1'b1;
        it.logit = lg;
        return it;
    endfunction

    function automatic logic signed [VW-1:0] rand_logit();
        case ($urandom_range(2))
            0: return 16'($urandom());
            1: return $signed(16'($urandom_range(0, 24575))) - 16'sd12288;
            default: return 16'($urandom_range(0, 16383));
        endcase
    endfunction

    function automatic t_item full_box(logic signed [VW-1:0] v, logic nf);
        t_item it;
        it = box_item(nf);
        it.enc_y = v; it.enc_x = v; it.enc_h = v; it.enc_w = v;
        it.anc_y = v; it.anc_x = v; it.anc_h = v; it.anc_w = v;
        return it;
    endfunction

    // extremes, logit before any box, extra logits, ignored new_frame
    task automatic test_directed();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        send_item(logit_item(16'sd16384));            // zero corners after reset
        program_regs(16'd0, 16'd6554, 16'd6554, 16'd13107, 16'd13107, 8'd3);
        send_item(full_box(16'sh7fff, 1'b1));
        send_item(logit_item(16'sh7fff));
        send_item(logit_item(-16'sh8000));
        send_item(logit_item(16'sd0));
        send_item(logit_item(16'sd4096));             // past class count, ignored
        send_item(full_box(-16'sh8000, 1'b0));
        send_item(logit_item(16'sd0));
        send_item(full_box(16'sd0, 1'b1));
        send_item(logit_item(16'sd100));
        send_item(full_box(-16'sd1, 1'b0));
        send_item(logit_item(-16'sd1));
        program_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'd255);
        send_item(full_box(16'sh7fff, 1'b0));         // huge exponent, corners clip
        send_item(logit_item(16'sh7fff));             // nothing beats the top threshold
        program_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 8'd2);
        send_item(full_box(16'sh5555, 1'b1));
        send_item(logit_item(16'shaaaa));
        send_item(logit_item(16'sh5555));
    endtask

    // zero reciprocal scales and zero class count
    task automatic test_zero_regs();
        program_regs(16'd100, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
        send_item(full_box(16'sd4096, 1'b1));
        send_item(logit_item(16'sh7fff));             // ignored, no classes
        program_regs(16'd100, 16'd0, 16'd0, 16'd0, 16'd0, 8'd4);
        send_item(logit_item(16'sh7fff));
        send_item(box_item(1'b0));
        send_item(logit_item(16'sd8192));
    endtask

    // random anchor/logit sequences with some stray items
    task automatic test_random_frames(input int n_items);
        int sent, run;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_item($urandom_range(1) ? logit_item(rand_logit())
                                            : box_item(1'($urandom_range(1))));
                sent++;
            end else begin
                send_item(box_item($urandom_range(3) == 0));
                sent++;
                run = $urandom_range(0, int'(n_classes) + 2);
                if (run > 12) run = $urandom_range(1, 12);
                for (int i = 0; i < run; i++) begin
                    send_item(logit_item(rand_logit()));
                    sent++;
                end
            end
        end
    endtask

    task automatic random_regs();
        logic [7:0] nc;
        nc = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 8));
        program_regs(16'($urandom()), 16'($urandom_range(1, 65535)),
                     16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                     16'($urandom_range(1, 65535)), nc);
    endtask

    // idle/stall mixes, each with fresh registers
    task automatic test_handshake_phases();
        int idle_mix  [5] = '{0, 81, 0, 31, 0};
        int stall_mix [5] = '{0, 0, 81, 31, 0};
        for (int p = 0; p < 5; p++) begin
            sender_idle_pct = idle_mix[p];
            receiver_stall_pct = stall_mix[p];
            if (p == 4) program_regs(16'd32768, 16'd6554, 16'd6554, 16'd13107, 16'd13107, 8'd6);
            else random_regs();
            test_random_frames(150);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.mode = 1'b0;
        item_ch.enc_y = '0; item_ch.enc_x = '0; item_ch.enc_h = '0; item_ch.enc_w = '0;
        item_ch.anchor_y = '0; item_ch.anchor_x = '0;
        item_ch.anchor_h = '0; item_ch.anchor_w = '0;
        item_ch.logit = '0;
        item_ch.new_frame = 1'b0;
        det_ch.ready = 1'b0;
        fail_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        build_exp2_table();
        thr = RST_SCORE_THRESHOLD;
        y_recip = RST_CENTRE_RECIP; x_recip = RST_CENTRE_RECIP;
        h_recip = RST_SIZE_RECIP;   w_recip = RST_SIZE_RECIP;
        n_classes = RST_CLASS_COUNT;
        for (int k = 0; k < 4; k++) corners[k] = '0;
        class_pos = '0;
        det_count = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_zero_regs();
        test_handshake_phases();

        // drain: let the last detections leave, then allow the block to settle
        item_ch.valid <= 1'b0;
        receiver_stall_pct = 0;
        @(posedge i_clk);
        while (pending_dets.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CY) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // run limit, well beyond the slowest legal run
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
design/ssdbd_pkg.sv
design/ssdbd_in_if.sv
design/ssdbd_out_if.sv
design/ssdbd_ctrl.sv
design/ssdbd_dp.sv
design/ssd_box_decode_score_filter_core.sv
dv/tb_ssd_box_decode_score_filter_core.sv
